@@ hdl/tmt_pkg.sv @@
// Shared types and constants of the trapezoidal move-time block.
// Used by tmt_front, tmt_queue, tmt_back and trapezoid_move_time_max.
// Depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package tmt_pkg;

    localparam int TMT_QUEUE_DEPTH = 2;

    localparam int NUM_W  = 81;  // widest dividend: 66-bit sum shifted up by 15
    localparam int DEN_W  = 62;  // widest divisor: product of the two limits
    localparam int RAD_W  = 64;  // radicand of the square root
    localparam int ROOT_W = 48;  // floor(2^16 * sqrt(radicand))

    localparam logic [31:0] TIME_SAT = 32'hFFFF_FFFF;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_STOP = 2'd0;
    localparam t_kind KIND_TRI  = 2'd1;
    localparam t_kind KIND_TRAP = 2'd2;

    // One classified joint, handed from the front end to the back end.
    // For the triangular case num holds the radicand in its low bits.
    typedef struct packed {
        t_kind              kind;
        logic               neg;
        logic [31:0]        av;
        logic [NUM_W-1:0]   num;
        logic [DEN_W-1:0]   den;
        logic               last;
    } t_job;

endpackage

`default_nettype wire

@@ hdl/tmt_front.sv @@
// Front end: takes one joint word, forms the distance and velocity terms,
// the limit products on one shared multiplier, and the case decision.
// Depends on tmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmt_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire logic [159:0]  i_s_tdata,
    input  wire logic          i_s_tlast,
    output logic               o_job_valid,
    input  wire logic          i_job_ready,
    output tmt_pkg::t_job      o_job
);
    import tmt_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_CALC = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]  r_state, n_state;
    logic [2:0]  r_cnt;

    logic [32:0] r_d;
    logic [31:0] r_av;
    logic        r_neg;
    logic [30:0] r_vlim;
    logic [30:0] r_alim;
    logic        r_last;

    logic [63:0] r_prod;
    logic [63:0] r_v2;
    logic [63:0] r_ad2;
    logic [63:0] r_vmax2;
    logic [63:0] r_add;
    logic [61:0] r_den;
    logic [63:0] r_diff;
    logic [63:0] r_k0;
    logic [65:0] r_k;
    logic        r_c1;
    logic        r_c2a;
    logic        r_c2;

    logic signed [31:0] w_pos, w_vel, w_tgt;
    logic signed [32:0] w_sd, w_vf;
    logic [32:0]        w_d;
    logic [32:0]        w_av;
    logic [30:0]        w_vlim_in, w_alim_in;
    logic [31:0]        w_ma, w_mb;
    logic [63:0]        w_mul;

    assign w_pos     = i_s_tdata[31:0];
    assign w_vel     = i_s_tdata[63:32];
    assign w_tgt     = i_s_tdata[95:64];
    assign w_vlim_in = i_s_tdata[126:96];
    assign w_alim_in = i_s_tdata[157:127];

    always_comb begin
        w_sd = 33'(w_pos) - 33'(w_tgt);
        w_d  = w_sd[32] ? 33'(-w_sd) : 33'(w_sd);
        w_vf = w_sd[32] ? -33'(w_vel) : 33'(w_vel);
        w_av = w_vf[32] ? 33'(-w_vf) : 33'(w_vf);
    end

    // Shared multiplier; the operand pair follows the step count.
    always_comb begin
        case (r_cnt)
            3'd0:    begin w_ma = r_av;            w_mb = r_av;              end
            3'd1:    begin w_ma = {1'b0, r_alim};  w_mb = r_d[31:0];         end
            3'd2:    begin w_ma = {1'b0, r_vlim};  w_mb = {1'b0, r_vlim};    end
            3'd3:    begin w_ma = {1'b0, r_vlim};  w_mb = r_av;              end
            3'd4:    begin w_ma = {1'b0, r_alim};  w_mb = {1'b0, r_vlim};    end
            default: begin w_ma = '0;              w_mb = '0;                end
        endcase
        w_mul = w_ma * w_mb;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:  if (i_s_tvalid) n_state = F_CALC;
            F_CALC:  if (r_cnt == 3'd7) n_state = F_PUSH;
            F_PUSH:  if (i_job_ready) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == F_CALC) r_cnt <= r_cnt + 3'd1;
            else                   r_cnt <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_s_tvalid) begin
            r_d    <= w_d;
            r_av   <= w_av[31:0];
            r_neg  <= w_vf[32];
            r_vlim <= (w_vlim_in == '0) ? 31'd1 : w_vlim_in;
            r_alim <= (w_alim_in == '0) ? 31'd1 : w_alim_in;
            r_last <= i_s_tlast;
        end
        if (r_state == F_CALC) begin
            r_prod <= w_mul;
            case (r_cnt)
                3'd1: r_v2 <= r_prod;
                3'd2: r_ad2 <= {r_prod[62:0], 1'b0}
                               + (r_d[32] ? {r_alim, 33'b0} : 64'b0);
                3'd3: r_vmax2 <= {r_prod[61:0], 2'b00};
                3'd4: r_add <= {r_prod[62:0], 1'b0};
                3'd5: begin
                    r_den  <= r_prod[61:0];
                    r_c1   <= !r_neg && (r_ad2 <= r_v2);
                    r_c2a  <= (r_v2 <= r_vmax2);
                    r_diff <= r_vmax2 - r_v2;
                end
                3'd6: begin
                    r_c2 <= r_c2a && (r_ad2 <= r_diff);
                    r_k0 <= r_ad2 + r_v2;
                    r_k  <= {2'b00, r_ad2} + {2'b00, r_v2};
                end
                3'd7: r_k <= r_k + (r_neg ? {2'b00, r_add} : 66'd0);
                default: ;
            endcase
        end
    end

    assign o_s_tready  = (r_state == F_IDLE);
    assign o_job_valid = (r_state == F_PUSH);

    always_comb begin
        o_job.neg  = r_neg;
        o_job.av   = r_av;
        o_job.last = r_last;
        if (r_c1) begin
            o_job.kind = KIND_STOP;
            o_job.num  = {33'b0, r_av, 16'b0};
            o_job.den  = {31'b0, r_alim};
        end else if (r_c2) begin
            o_job.kind = KIND_TRI;
            o_job.num  = {17'b0, r_k0};
            o_job.den  = {31'b0, r_alim};
        end else begin
            o_job.kind = KIND_TRAP;
            o_job.num  = {r_k, 15'b0};
            o_job.den  = r_den;
        end
    end

endmodule

`default_nettype wire

@@ hdl/tmt_queue.sv @@
// Short first-in first-out queue of classified joints between the front
// and back ends. Depends on tmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmt_queue #(
    parameter int DEPTH = tmt_pkg::TMT_QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push_valid,
    output logic            o_push_ready,
    input  tmt_pkg::t_job   i_push,
    output logic            o_pop_valid,
    input  wire logic       i_pop_ready,
    output tmt_pkg::t_job   o_pop
);
    import tmt_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          w_push, w_pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop        = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (w_pop)  r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (w_push && !w_pop)      r_count <= r_count + 1'b1;
            else if (w_pop && !w_push) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_push;
    end

endmodule

`default_nettype wire

@@ hdl/tmt_back.sv @@
// Back end: bit-serial square root and restoring divider that turn a
// classified joint into its time, plus the running maximum and the output
// register. Depends on tmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmt_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_job_valid,
    output logic               o_job_ready,
    input  tmt_pkg::t_job      i_job,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output logic [63:0]        o_m_tdata,
    output logic               o_m_tlast
);
    import tmt_pkg::*;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_SQRT = 3'd1;
    localparam logic [2:0] B_FIX  = 3'd2;
    localparam logic [2:0] B_DIV  = 3'd3;
    localparam logic [2:0] B_DONE = 3'd4;

    logic [2:0]        r_state;
    logic [6:0]        r_cnt;
    logic              r_neg, r_last;
    logic [31:0]       r_av;
    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic [31:0]       r_q;
    logic              r_sat;
    logic [RAD_W-1:0]  r_rad;
    logic [49:0]       r_srem;
    logic [ROOT_W-1:0] r_root;
    logic [31:0]       r_max;
    logic              r_out_valid, r_out_last;
    logic [31:0]       r_out_time, r_out_long;

    logic [51:0]       w_s_sh, w_trial;
    logic              w_s_ok;
    logic [DEN_W:0]    w_d_sh;
    logic              w_d_ok;
    logic [32:0]       w_q_next;
    logic [ROOT_W-1:0] w_avs;
    logic [ROOT_W:0]   w_fix;
    logic [31:0]       w_t, w_newmax;
    logic              w_load;

    assign w_s_sh  = {r_srem, r_rad[RAD_W-1 -: 2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_s_ok  = (w_s_sh >= w_trial);

    assign w_d_sh   = {r_rem, r_num[NUM_W-1]};
    assign w_d_ok   = (w_d_sh >= {1'b0, r_den});
    assign w_q_next = {r_q, w_d_ok};

    assign w_avs = {r_av, 16'b0};
    always_comb begin
        if (r_neg)                 w_fix = {1'b0, r_root} + {1'b0, w_avs};
        else if (r_root >= w_avs)  w_fix = {1'b0, r_root - w_avs};
        else                       w_fix = '0;
    end

    assign w_t      = r_sat ? TIME_SAT : r_q;
    assign w_newmax = (w_t > r_max) ? w_t : r_max;
    assign w_load   = (r_state == B_DONE) && (!r_out_valid || i_m_tready);

    assign o_job_ready = (r_state == B_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_cnt       <= '0;
            r_max       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                B_IDLE: if (i_job_valid) begin
                    r_state <= (i_job.kind == KIND_TRI) ? B_SQRT : B_DIV;
                    r_cnt   <= '0;
                end
                B_SQRT: begin
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'(ROOT_W - 1)) r_state <= B_FIX;
                end
                B_FIX: begin
                    r_state <= B_DIV;
                    r_cnt   <= '0;
                end
                B_DIV: begin
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'(NUM_W - 1)) r_state <= B_DONE;
                end
                B_DONE: if (w_load) r_state <= B_IDLE;
                default: r_state <= B_IDLE;
            endcase

            if (w_load) begin
                r_out_valid <= 1'b1;
                r_max       <= r_last ? 32'd0 : w_newmax;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: if (i_job_valid) begin
                r_neg  <= i_job.neg;
                r_av   <= i_job.av;
                r_last <= i_job.last;
                r_num  <= i_job.num;
                r_den  <= i_job.den;
                r_rad  <= i_job.num[RAD_W-1:0];
                r_rem  <= '0;
                r_q    <= '0;
                r_sat  <= 1'b0;
                r_srem <= '0;
                r_root <= '0;
            end
            B_SQRT: begin
                r_rad <= {r_rad[RAD_W-3:0], 2'b00};
                if (w_s_ok) begin
                    r_srem <= 50'(w_s_sh - w_trial);
                    r_root <= {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_srem <= w_s_sh[49:0];
                    r_root <= {r_root[ROOT_W-2:0], 1'b0};
                end
            end
            B_FIX: r_num <= {32'b0, w_fix};
            B_DIV: begin
                r_num <= {r_num[NUM_W-2:0], 1'b0};
                r_rem <= w_d_ok ? DEN_W'(w_d_sh - {1'b0, r_den}) : w_d_sh[DEN_W-1:0];
                r_q   <= w_q_next[31:0];
                if (w_q_next[32]) r_sat <= 1'b1;
            end
            default: ;
        endcase

        if (w_load) begin
            r_out_time <= w_t;
            r_out_long <= w_newmax;
            r_out_last <= r_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_long, r_out_time};
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

@@ hdl/trapezoid_move_time_max.sv @@
// Top level of the trapezoidal move-time block: front end, queue, back end.
// Depends on tmt_pkg, tmt_front, tmt_queue and tmt_back.
`timescale 1ns / 1ps
`default_nettype none

// Each input word is one joint; the block returns the time that joint needs
// to reach its target under a trapezoidal velocity profile (Q16.16 seconds,
// saturated at all ones), together with the largest time seen since the
// last word marked with tlast, and that running maximum is cleared after a
// tlast word. Limits of zero are taken as the smallest positive value. The
// front end forms the products of the distance, velocity and limits on one
// shared 32-by-32 multiplier and chooses the stopping, triangular or
// trapezoidal case. The back end then runs an 81-step restoring divider for
// the stopping and trapezoidal cases; for the triangular case a 48-step
// square root comes first. Both work one bit per cycle. The back end sets
// the sustained rate. A queue of QUEUE_DEPTH classified joints lets the
// front end go on taking words while the back end works and while a
// finished result waits in the output register.
module trapezoid_move_time_max #(
    parameter int QUEUE_DEPTH = tmt_pkg::TMT_QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // Input word: one joint.
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    // From bit 0: current_position[31:0], current_velocity[31:0],
    // target_position[31:0], vel_limit[30:0], acc_limit[30:0],
    // two zero bits.
    input  wire logic [159:0]  i_s_tdata,
    input  wire logic          i_s_tlast,   // last_joint
    // Output word: one result per joint.
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    // From bit 0: joint_time[31:0], longest_time[31:0].
    output logic [63:0]        o_m_tdata,
    output logic               o_m_tlast    // solution_done
);
    import tmt_pkg::*;

    logic f_job_valid, f_job_ready;
    logic q_job_valid, q_job_ready;
    t_job f_job, q_job;

    tmt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_job_valid (f_job_valid),
        .i_job_ready (f_job_ready),
        .o_job       (f_job)
    );

    tmt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_job_valid),
        .o_push_ready (f_job_ready),
        .i_push       (f_job),
        .o_pop_valid  (q_job_valid),
        .i_pop_ready  (q_job_ready),
        .o_pop        (q_job)
    );

    tmt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_job_valid),
        .o_job_ready (q_job_ready),
        .i_job       (q_job),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    // The running maximum always covers the joint reported with it.
    a_long_covers_joint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[63:32] >= o_m_tdata[31:0]))
        else $error("longest_time below joint_time");

    // No result is shown in the cycle after reset.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output word valid straight after reset");

endmodule

`default_nettype wire

@@ sim/trapezoid_move_time_max_test.sv @@
// Self-checking testbench for trapezoid_move_time_max: joint move times and the
// running maximum over a solution, predicted in the bench and compared per word.
// Depends on the RTL of the block and its package tmt_pkg.
`timescale 1ns / 1ps

module trapezoid_move_time_max_test;

    // Clock and reset.
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // Input stream: one joint per word.
    logic          i_s_tvalid = 1'b0;
    logic          o_s_tready;
    // From bit 0: current_position, current_velocity, target_position,
    // vel_limit[30:0], acc_limit[30:0], two zero bits.
    logic [159:0]  i_s_tdata = '0;
    logic          i_s_tlast = 1'b0;   // last_joint

    // Output stream: one result word per joint.
    logic          o_m_tvalid;
    logic          i_m_tready = 1'b0;
    // From bit 0: joint_time, longest_time.
    logic [63:0]   o_m_tdata;
    logic          o_m_tlast;          // solution_done

    trapezoid_move_time_max dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // One predicted result word.
    typedef struct packed {
        logic [31:0] joint_time;
        logic [31:0] longest_time;
        logic        done;
    } t_move_result;

    t_move_result move_results_due[$];
    logic [160:0] words_to_send[$];    // {last, tdata} waiting for the driver
    logic [31:0]  solution_max = '0;
    int           errors = 0;
    int           quiet_cycles = 0;
    bit           send_idles = 1'b1;   // sender inserts random gaps
    bit           recv_idles = 1'b1;   // receiver inserts random stalls
    bit           recv_hold = 1'b0;    // long receiver hold-off in progress

    // floor(2^16 * sqrt(n)), digit-by-digit, 48 result bits.
    function automatic logic [47:0] root_q16(input logic [63:0] n);
        logic [67:0] rem;
        logic [67:0] trial;
        logic [47:0] root;
        rem = '0;
        root = '0;
        for (int i = 0; i < 48; i++) begin
            rem = (rem << 2) | ((i < 32) ? 68'((n >> (62 - 2 * i)) & 64'd3) : 68'd0);
            trial = {18'd0, root, 2'b01};
            if (rem >= trial) begin
                rem = rem - trial;
                root = {root[46:0], 1'b1};
            end else begin
                root = {root[46:0], 1'b0};
            end
        end
        return root;
    endfunction

    function automatic logic [31:0] clamp_time(input logic [127:0] x);
        return (x > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
    endfunction

    // Time for one joint under the trapezoidal profile, truncated and saturated.
    function automatic logic [31:0] joint_move_time(
        input logic signed [31:0] pos, input logic signed [31:0] vel,
        input logic signed [31:0] tgt, input logic [30:0] vmax_in,
        input logic [30:0] amax_in);
        logic signed [33:0] dist_s;
        logic signed [33:0] vel_s;
        logic [127:0]       span, speed, vlim, alim, v_sq, two_ad, vmax_sq, num, root;
        logic               neg;
        vlim = (vmax_in == 0) ? 128'd1 : 128'(vmax_in);
        alim = (amax_in == 0) ? 128'd1 : 128'(amax_in);
        dist_s = 34'(pos) - 34'(tgt);
        vel_s = 34'(vel);
        if (dist_s < 0) vel_s = -vel_s;
        span = 128'((dist_s < 0) ? -dist_s : dist_s);
        neg = vel_s < 0;
        speed = 128'(neg ? -vel_s : vel_s);
        v_sq = speed * speed;
        two_ad = 2 * alim * span;
        vmax_sq = 4 * vlim * vlim;
        if (!neg && two_ad <= v_sq) begin
            return clamp_time((speed << 16) / alim);
        end else if (v_sq <= vmax_sq && two_ad <= vmax_sq - v_sq) begin
            root = 128'(root_q16(64'(two_ad + v_sq)));
            if (neg) num = root + (speed << 16);
            else num = (root >= (speed << 16)) ? root - (speed << 16) : 128'd0;
            return clamp_time(num / alim);
        end else begin
            num = two_ad + v_sq + (neg ? 2 * vlim * speed : 128'd0);
            return clamp_time((num << 15) / (alim * vlim));
        end
    endfunction

    // Queues one joint word for the driver together with its expected result.
    task automatic send_joint(input logic [31:0] pos, input logic [31:0] vel,
                              input logic [31:0] tgt, input logic [30:0] vmax,
                              input logic [30:0] amax, input logic last);
        t_move_result r;
        r.joint_time = joint_move_time(pos, vel, tgt, vmax, amax);
        if (r.joint_time > solution_max) solution_max = r.joint_time;
        r.longest_time = solution_max;
        r.done = last;
        if (last) solution_max = '0;
        move_results_due.insert(move_results_due.size(), r);
        words_to_send.insert(words_to_send.size(), {last, 2'b00, amax, vmax, tgt, vel, pos});
        while (words_to_send.size() > 1) @(posedge i_clk);
    endtask

    // Random joint in one of four randomly picked ranges of magnitudes; half of them are realistic sizes.
    task automatic send_random_joint(input logic last);
        logic [31:0] pos, vel, tgt;
        logic [30:0] vmax, amax;
        pos = $urandom;
        tgt = $urandom;
        vel = $urandom;
        vmax = 31'($urandom);
        amax = 31'($urandom);
        case ($urandom_range(3))
            0: begin
                // small moves: tri and stopping cases are common
                tgt = pos + 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh2_0000);
                vel = 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh2_0000);
                vmax = 31'($urandom_range(1, 32'h0004_0000));
                amax = 31'($urandom_range(1, 32'h0008_0000));
            end
            1: begin
                vmax = 31'($urandom_range(1, 32'h0010_0000));
                amax = 31'($urandom_range(1, 32'h0010_0000));
                vel = 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh10_0000);
            end
            2: begin
                if ($urandom_range(1)) vmax = 31'($urandom_range(0, 3));
                if ($urandom_range(1)) amax = 31'($urandom_range(0, 3));
            end
            default: ;
        endcase
        send_joint(pos, vel, tgt, vmax, amax, last);
    endtask

    // Input driver: presents the next queued word once the current one is
    // taken, with random gaps; the only process that drives the input side.
    always @(posedge i_clk) begin
        logic [160:0] w;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (words_to_send.size() != 0 && !(send_idles && $urandom_range(99) < 28)) begin
                w = words_to_send.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= w[159:0];
                i_s_tlast  <= w[160];
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver stalls; a hold-off can suspend it entirely.
    always @(posedge i_clk) begin
        if (!i_rst_n) i_m_tready <= 1'b0;
        else i_m_tready <= !recv_hold && !(recv_idles && $urandom_range(99) < 28);
    end

    // Compares each accepted result word with the oldest prediction.
    always @(posedge i_clk) begin
        t_move_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (move_results_due.size() == 0) begin
                $display("%0t: unexpected result word %h last %b", $time, o_m_tdata, o_m_tlast);
                errors++;
            end else begin
                want = move_results_due.pop_front();
                if (o_m_tdata[31:0] !== want.joint_time) begin
                    $display("%0t: joint_time expected %h actual %h",
                             $time, want.joint_time, o_m_tdata[31:0]);
                    errors++;
                end
                if (o_m_tdata[63:32] !== want.longest_time) begin
                    $display("%0t: longest_time expected %h actual %h",
                             $time, want.longest_time, o_m_tdata[63:32]);
                    errors++;
                end
                if (o_m_tlast !== want.done) begin
                    $display("%0t: solution_done expected %b actual %b",
                             $time, want.done, o_m_tlast);
                    errors++;
                end
            end
        end
    end

    // Watchdog: ends the run when neither side hands over a word; the deliberate
    // hold-off is far shorter than this limit.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Extremes of the fields and each named special case.
    task automatic test_directed();
        send_joint(0, 0, 0, 31'h0001_0000, 31'h0001_0000, 1'b1);       // no move, no speed
        send_joint(0, 0, 0, 0, 0, 1'b0);                                 // zero limits
        send_joint(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 1'b0); // huge, saturates
        send_joint(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                   31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
        send_joint(32'h0001_0000, 32'h0008_0000, 0, 31'h0002_0000, 31'h0001_0000, 1'b0); // stop
        send_joint(32'h0001_0000, 32'h0000_8000, 0, 31'h0004_0000, 31'h0001_0000, 1'b0); // tri v>0
        send_joint(0, 32'h0000_8000, 32'h0001_0000, 31'h0004_0000, 31'h0001_0000, 1'b0); // tri v<0
        send_joint(32'h0010_0000, 0, 0, 31'h0001_0000, 31'h0001_0000, 1'b0);  // trapezoid
        send_joint(32'h0010_0000, 32'hFFFF_0000, 0, 31'h0001_0000, 31'h0001_0000, 1'b1);
        send_joint(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001,
                   31'h0000_0001, 31'h7FFF_FFFF, 1'b1);
        send_joint(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                   31'h5555_5555, 31'h2AAA_AAAA, 1'b0);
        send_joint(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555,
                   31'h2AAA_AAAA, 31'h5555_5555, 1'b1);
    endtask

    // Random solutions of a few joints each; gaps on both sides.
    task automatic test_random_solutions(input int joints);
        for (int n = 0; n < joints; n++) send_random_joint($urandom_range(3) == 0);
    endtask

    // Both sides run without gaps.
    task automatic test_full_rate(input int joints);
        send_idles = 1'b0;
        recv_idles = 1'b0;
        test_random_solutions(joints);
        send_idles = 1'b1;
        recv_idles = 1'b1;
    endtask

    // The receiver holds off while the sender keeps offering words, so the
    // queue fills and the input stalls.
    task automatic test_output_hold_off();
        recv_hold = 1'b1;
        fork
            begin
                for (int c = 0; c < 1500; c++) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            test_random_solutions(30);
        join
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_solutions(900);
        test_output_hold_off();
        test_full_rate(300);
        test_random_solutions(600);
        send_joint(0, 0, 32'h0000_0100, 31'h0001_0000, 31'h0001_0000, 1'b1);
        while (move_results_due.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/tmt_pkg.sv
hdl/tmt_front.sv
hdl/tmt_queue.sv
hdl/tmt_back.sv
hdl/trapezoid_move_time_max.sv
sim/trapezoid_move_time_max_test.sv
